// ===== sv/rcht_pkg.sv =====
// Shared types and constants of the reference-counted handle table.
`default_nettype none

package rcht_pkg;

   localparam int DEF_TABLE_SLOTS = 128;
   localparam int DEF_REF_BITS    = 16;
   localparam int DEF_HANDLE_BITS = 32;

   localparam int SLOT_PORT_W   = 7;
   localparam int HANDLE_PORT_W = 32;
   localparam int POS_W         = 63;
   localparam int OFF_W         = 64;

   // free-slot search works on groups of this many valid bits
   localparam int GRP_W     = 16;
   localparam int GRP_LOW_W = 4;

   typedef enum logic [1:0] {
      ACT_OPEN = 2'd0,
      ACT_ADD  = 2'd1,
      ACT_DROP = 2'd2,
      ACT_MOVE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_INVAL = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      WH_START = 2'd0,
      WH_CUR   = 2'd1,
      WH_SIZE  = 2'd2,
      WH_BAD   = 2'd3
   } whence_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

endpackage

`default_nettype wire

// ===== sv/refcounted_handle_table_top.sv =====
// Reference-counted handle table: a fixed table of open-file entries.
//
// Request channel (req_*): one operation word per handshake: open, add
// reference, drop reference or move position. Response channel (rsp_*): one
// word per request, in request order, with status, slot, position and the
// handle to close when a drop frees its entry.
// The accept edge issues the entry memory read; the execute state then
// modifies the entry and writes it back together with the response
// register, and waits there while the output register is still full. The
// registered read of the entry memory and the write-back that follows it
// mean that no request is accepted while the previous one executes.
// The lowest free slot for open comes from a registered two-level search over
// the valid bits, refreshed every cycle.
// Reset empties the table at once (valid bits clear); no clearing pass.
// While the receiver stalls, one response waits in the output register and one
// more request may be accepted; it then holds in its execute cycle until the
// output register drains.
`default_nettype none

module refcounted_handle_table_top import rcht_pkg::*; #(
   parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
   parameter int REF_BITS    = DEF_REF_BITS,
   parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_action,
   input  wire logic [SLOT_PORT_W-1:0]    req_slot,
   input  wire logic [HANDLE_PORT_W-1:0]  req_handle,
   input  wire logic [POS_W-1:0]          req_start_position,
   input  wire logic signed [OFF_W-1:0]   req_offset,
   input  wire logic [1:0]                req_whence,
   input  wire logic [POS_W-1:0]          req_file_size,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [SLOT_PORT_W-1:0]         rsp_slot_out,
   output logic signed [OFF_W-1:0]        rsp_position,
   output logic                           rsp_freed,
   output logic [HANDLE_PORT_W-1:0]       rsp_freed_handle
);

   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int MEM_W  = REF_BITS + POS_W + HANDLE_BITS;

   fsm_type state_ff, state_in;

   logic req_fire, ex_fire;

   // latched request
   logic [1:0]               act_ff;
   logic [SLOT_PORT_W-1:0]   slot_ff;
   logic [HANDLE_PORT_W-1:0] handle_ff;
   logic [POS_W-1:0]         start_ff;
   logic [OFF_W-1:0]         off_ff;
   logic [1:0]               whence_ff;
   logic [POS_W-1:0]         fsize_ff;

   // entry memory and valid map
   logic [SLOT_W-1:0] rd_idx, slot_idx_ff, wr_addr;
   logic              mem_wr_en;
   logic [MEM_W-1:0]  wr_word, rd_word;
   logic              vm_wr_en, vm_wr_set, slot_valid, free_any;
   logic [SLOT_W-1:0] free_idx;

   logic [REF_BITS-1:0]    rd_refs;
   logic [POS_W-1:0]       rd_pos;
   logic [HANDLE_BITS-1:0] rd_handle;

   // execute results
   logic                     hit;
   logic [POS_W-1:0]         seek_base;
   logic [OFF_W:0]           seek_sum;
   logic                     seek_ok;
   status_type               res_status;
   logic [SLOT_PORT_W-1:0]   res_slot;
   logic [OFF_W-1:0]         res_pos;
   logic                     res_freed;
   logic [HANDLE_PORT_W-1:0] res_fhandle;

   logic                     rsp_valid_ff;
   logic [1:0]               rsp_status_ff;
   logic [SLOT_PORT_W-1:0]   rsp_slot_ff;
   logic [OFF_W-1:0]         rsp_pos_ff;
   logic                     rsp_freed_ff;
   logic [HANDLE_PORT_W-1:0] rsp_fhandle_ff;

   // ---------------- control ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (ex_fire) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == FSM_IDLE);
      ex_fire   = (state_ff == FSM_EXEC) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff      <= req_action;
         slot_ff     <= req_slot;
         slot_idx_ff <= rd_idx;
         handle_ff   <= req_handle;
         start_ff    <= req_start_position;
         off_ff      <= req_offset;
         whence_ff   <= req_whence;
         fsize_ff    <= req_file_size;
      end
   end

   assign rd_idx = SLOT_W'(req_slot);

   rcht_entry_ram #(
      .DEPTH (TABLE_SLOTS),
      .WIDTH (MEM_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (req_fire),
      .rd_addr (rd_idx),
      .rd_data (rd_word)
   );

   rcht_valid_map #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .SLOT_W      (SLOT_W)
   ) u_vmap (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (vm_wr_en),
      .wr_set   (vm_wr_set),
      .wr_idx   (wr_addr),
      .rd_idx   (slot_idx_ff),
      .rd_valid (slot_valid),
      .free_any (free_any),
      .free_idx (free_idx)
   );

   assign {rd_refs, rd_pos, rd_handle} = rd_word;

   // ---------------- execute ----------------
   always_comb begin
      hit = (int'(slot_ff) < TABLE_SLOTS) && slot_valid;

      case (whence_type'(whence_ff))
         WH_CUR:  seek_base = rd_pos;
         WH_SIZE: seek_base = fsize_ff;
         default: seek_base = '0;
      endcase
      seek_sum = (OFF_W + 1)'(seek_base) + {off_ff[OFF_W-1], off_ff};
      seek_ok  = (whence_type'(whence_ff) != WH_BAD) && (seek_sum[OFF_W:OFF_W-1] == 2'b00);

      res_status  = ST_OK;
      res_slot    = slot_ff;
      res_pos     = '1;
      res_freed   = 1'b0;
      res_fhandle = '0;
      wr_addr     = slot_idx_ff;
      wr_word     = rd_word;
      mem_wr_en   = 1'b0;
      vm_wr_en    = 1'b0;
      vm_wr_set   = 1'b0;

      if (action_type'(act_ff) == ACT_OPEN) begin
         if (free_any) begin
            wr_addr   = free_idx;
            wr_word   = {REF_BITS'(1), start_ff, HANDLE_BITS'(handle_ff)};
            mem_wr_en = ex_fire;
            vm_wr_en  = ex_fire;
            vm_wr_set = 1'b1;
            res_slot  = SLOT_PORT_W'(free_idx);
            res_pos   = {1'b0, start_ff};
         end else begin
            res_status = ST_FULL;
            res_slot   = '0;
         end
      end else if (!hit) begin
         res_status = ST_EMPTY;
      end else begin
         case (action_type'(act_ff))
            ACT_ADD: begin
               // saturate the count
               if (!(&rd_refs)) begin
                  wr_word   = {rd_refs + REF_BITS'(1), rd_pos, rd_handle};
                  mem_wr_en = ex_fire;
               end
               res_pos = {1'b0, rd_pos};
            end
            ACT_DROP: begin
               res_pos = {1'b0, rd_pos};
               if (rd_refs > REF_BITS'(1)) begin
                  wr_word   = {rd_refs - REF_BITS'(1), rd_pos, rd_handle};
                  mem_wr_en = ex_fire;
               end else begin
                  vm_wr_en    = ex_fire;
                  res_freed   = 1'b1;
                  res_fhandle = HANDLE_PORT_W'(rd_handle);
               end
            end
            ACT_MOVE: begin
               if (seek_ok) begin
                  wr_word   = {rd_refs, seek_sum[POS_W-1:0], rd_handle};
                  mem_wr_en = ex_fire;
                  res_pos   = {1'b0, seek_sum[POS_W-1:0]};
               end else begin
                  res_status = ST_INVAL;
               end
            end
            default: res_status = ST_EMPTY;
         endcase
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ex_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ex_fire) begin
         rsp_status_ff  <= res_status;
         rsp_slot_ff    <= res_slot;
         rsp_pos_ff     <= res_pos;
         rsp_freed_ff   <= res_freed;
         rsp_fhandle_ff <= res_fhandle;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_out     = rsp_slot_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_freed        = rsp_freed_ff;
   assign rsp_freed_handle = rsp_fhandle_ff;

   // ---------------- assertions ----------------
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request accepted while one is executing");

   a_exec_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_EXEC) && !ex_fire |=> (state_ff == FSM_EXEC))
      else $error("execute left without writing the response");

   a_error_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_OK) |-> (&rsp_pos_ff) && !rsp_freed_ff)
      else $error("error response carries a position or a freed entry");

   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_FULL) |-> (rsp_slot_ff == '0))
      else $error("table-full response names a slot");

   a_open_marks: assert property (@(posedge clock) disable iff (reset)
      ex_fire && vm_wr_en && vm_wr_set |=> !(ex_fire && vm_wr_en))
      else $error("valid map written on consecutive cycles");

endmodule

`default_nettype wire

// ===== sv/rcht_entry_ram.sv =====
// Entry memory: one write port, one registered read port.
`default_nettype none

module rcht_entry_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 111
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/rcht_valid_map.sv =====
// Valid bits of all entries and the lowest-free-slot search over them.
`default_nettype none

module rcht_valid_map import rcht_pkg::*; #(
   parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
   parameter int SLOT_W      = $clog2(DEF_TABLE_SLOTS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic              wr_set,
   input  wire logic [SLOT_W-1:0] wr_idx,
   input  wire logic [SLOT_W-1:0] rd_idx,
   output logic                   rd_valid,
   output logic                   free_any,
   output logic      [SLOT_W-1:0] free_idx
);

   localparam int NGRP = (TABLE_SLOTS + GRP_W - 1) / GRP_W;

   logic [TABLE_SLOTS-1:0]  valid_ff;
   logic [NGRP*GRP_W-1:0]   padded;
   logic [NGRP-1:0]         grp_any_in;
   logic [NGRP-1:0]         grp_any_ff;
   logic [GRP_LOW_W-1:0]    grp_low_in [NGRP];
   logic [GRP_LOW_W-1:0]    grp_low_ff [NGRP];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= wr_set;
      end
   end

   assign rd_valid = valid_ff[rd_idx];

   // pad slots past the table end as taken
   always_comb begin
      padded = '1;
      padded[TABLE_SLOTS-1:0] = valid_ff;
   end

   // first stage: lowest free bit inside each group
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g] = ~&padded[g*GRP_W +: GRP_W];
         grp_low_in[g] = '0;
         for (int b = GRP_W - 1; b >= 0; b--) begin
            if (!padded[g*GRP_W + b]) begin
               grp_low_in[g] = GRP_LOW_W'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_any_ff <= grp_any_in;
      grp_low_ff <= grp_low_in;
   end

   // second stage: lowest group that has a free bit
   always_comb begin
      int sel;
      sel = 0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            sel = g * GRP_W + int'(grp_low_ff[g]);
         end
      end
      free_any = |grp_any_ff;
      free_idx = SLOT_W'(sel);
   end

endmodule

`default_nettype wire
